// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BSNC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define BSNC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/bsnc_pkg.sv -----
package bsnc_pkg;

	// Storage geometry
	localparam int CODEBOOK_DEPTH = 256;
	localparam int BLOCK_PIXELS   = 16;
	localparam int ENTRY_W        = $clog2(CODEBOOK_DEPTH);
	localparam int PIX_W          = $clog2(BLOCK_PIXELS);
	localparam int ADDR_W         = ENTRY_W + PIX_W;
	localparam int STORE_WORDS    = CODEBOOK_DEPTH * BLOCK_PIXELS;

	// Word fields
	localparam int DATA_W       = 32;
	localparam int ENTRY_IDX_W  = 8;
	localparam int NUM_CHANNELS = 4;
	localparam int SAD_W        = 10;
	localparam int DIST_W       = 14;
	localparam logic [DIST_W-1:0] DIST_ALL_ONES = {DIST_W{1'b1}};
	localparam logic [PIX_W-1:0]  PIX_LAST = PIX_W'(BLOCK_PIXELS - 1);

	// Configuration port
	localparam int PADDR_W     = 3;
	localparam int CHAN_CFG_W  = 3;
	localparam int ENT_CFG_W   = 9;
	localparam logic [CHAN_CFG_W-1:0] CHAN_RESET = CHAN_CFG_W'(4);
	localparam logic [ENT_CFG_W-1:0]  ENT_RESET  = ENT_CFG_W'(256);

	// Register indexes (paddr bit 2)
	localparam logic REG_CHANNEL_COUNT  = 1'b0;
	localparam logic REG_ENTRIES_IN_USE = 1'b1;

	// Word opcodes
	localparam logic OP_CB_WRITE    = 1'b0;
	localparam logic OP_BLOCK_PIXEL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Settings derived from the registers
	typedef struct packed {
		logic [NUM_CHANNELS-1:0] chan_mask;
		logic [ENTRY_W-1:0]      last_entry;
	} cfg_t;

	// Position of a codebook read
	typedef struct packed {
		logic [ENTRY_W-1:0] entry;
		logic [PIX_W-1:0]   pix;
	} rd_tag_t;

	// Sum of absolute byte differences over the enabled channels
	function automatic logic [SAD_W-1:0] pixel_sad(
		input logic [DATA_W-1:0]       x,
		input logic [DATA_W-1:0]       y,
		input logic [NUM_CHANNELS-1:0] mask
	);
		logic [SAD_W-1:0] sum;
		logic [7:0]       bx;
		logic [7:0]       by;
		sum = '0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			bx = x[8*c +: 8];
			by = y[8*c +: 8];
			if (mask[c]) begin
				sum = sum + SAD_W'((bx > by) ? (bx - by) : (by - bx));
			end
		end
		return sum;
	endfunction

endpackage

// ----- hw/rtl/bsnc_in_if.sv -----
interface bsnc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  op;
	logic [bsnc_pkg::ENTRY_IDX_W-1:0]      entry_index;
	logic [bsnc_pkg::PIX_W-1:0]            pixel_index;
	logic [bsnc_pkg::DATA_W-1:0]           pixel_data;

	modport source (output valid, op, entry_index, pixel_index, pixel_data, input ready);
	modport sink (input valid, op, entry_index, pixel_index, pixel_data, output ready);
endinterface

// ----- hw/rtl/bsnc_out_if.sv -----
interface bsnc_out_if;
	logic                             valid;
	logic                             ready;
	logic [bsnc_pkg::ENTRY_IDX_W-1:0] best_index;

	modport source (output valid, best_index, input ready);
	modport sink (input valid, best_index, output ready);
endinterface

// ----- hw/rtl/bsnc_cfg_regs.sv -----
module bsnc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bsnc_pkg::PADDR_W-1:0]   paddr,
	input  logic [bsnc_pkg::DATA_W-1:0]    pwdata,
	output logic [bsnc_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output bsnc_pkg::cfg_t                 cfg
);

	logic [bsnc_pkg::CHAN_CFG_W-1:0] chan_q;
	logic [bsnc_pkg::ENT_CFG_W-1:0]  ent_q;
	logic                            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= bsnc_pkg::CHAN_RESET;
			ent_q  <= bsnc_pkg::ENT_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				bsnc_pkg::REG_CHANNEL_COUNT:  chan_q <= pwdata[bsnc_pkg::CHAN_CFG_W-1:0];
				bsnc_pkg::REG_ENTRIES_IN_USE: ent_q  <= pwdata[bsnc_pkg::ENT_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[2])
			bsnc_pkg::REG_CHANNEL_COUNT:  prdata = bsnc_pkg::DATA_W'(chan_q);
			bsnc_pkg::REG_ENTRIES_IN_USE: prdata = bsnc_pkg::DATA_W'(ent_q);
			default:                      prdata = '0;
		endcase
	end

	// Clamp channel count to 1..4 and turn it into a byte mask
	always_comb begin
		for (int c = 0; c < bsnc_pkg::NUM_CHANNELS; c++) begin
			cfg.chan_mask[c] = (c == 0) ||
				(32'(c) < 32'(chan_q));
		end
	end

	// Clamp entry count to 1..depth; keep the index of the last entry searched
	always_comb begin
		if (ent_q == '0) begin
			cfg.last_entry = '0;
		end else if (32'(ent_q) > 32'(bsnc_pkg::CODEBOOK_DEPTH)) begin
			cfg.last_entry = bsnc_pkg::ENTRY_W'(bsnc_pkg::CODEBOOK_DEPTH - 1);
		end else begin
			cfg.last_entry = bsnc_pkg::ENTRY_W'(ent_q - 1'b1);
		end
	end

endmodule

// ----- hw/rtl/bsnc_store.sv -----
module bsnc_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cb_we,
	input  logic [bsnc_pkg::ADDR_W-1:0]   cb_waddr,
	input  logic                          blk_we,
	input  logic [bsnc_pkg::PIX_W-1:0]    blk_waddr,
	input  logic [bsnc_pkg::DATA_W-1:0]   wdata,
	input  logic                          rd_en,
	input  bsnc_pkg::rd_tag_t             rd_tag,
	output logic                          vld_s1,
	output bsnc_pkg::rd_tag_t             tag_s1,
	output logic [bsnc_pkg::DATA_W-1:0]   cb_s1,
	output logic [bsnc_pkg::DATA_W-1:0]   blk_s1
);

	logic [bsnc_pkg::DATA_W-1:0] cb_mem  [bsnc_pkg::STORE_WORDS];
	logic [bsnc_pkg::DATA_W-1:0] blk_mem [bsnc_pkg::BLOCK_PIXELS];

	// Codebook memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cb_we) begin
			cb_mem[cb_waddr] <= wdata;
		end
		if (rd_en) begin
			cb_s1 <= cb_mem[{rd_tag.entry, rd_tag.pix}];
		end
	end

	// Source block buffer, read at the same pixel as the codebook
	always_ff @(posedge clk) begin
		if (blk_we) begin
			blk_mem[blk_waddr] <= wdata;
		end
		if (rd_en) begin
			blk_s1 <= blk_mem[rd_tag.pix];
		end
	end

	// Carry the read position along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			tag_s1 <= rd_tag;
		end
	end

endmodule

// ----- hw/rtl/bsnc_sad_acc.sv -----
module bsnc_sad_acc (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [bsnc_pkg::NUM_CHANNELS-1:0]   chan_mask,
	input  logic                                vld_s1,
	input  bsnc_pkg::rd_tag_t                   tag_s1,
	input  logic [bsnc_pkg::DATA_W-1:0]         cb_s1,
	input  logic [bsnc_pkg::DATA_W-1:0]         blk_s1,
	output logic                                busy,
	output logic [bsnc_pkg::ENTRY_W-1:0]        best_entry
);

	logic                          vld_s2;
	bsnc_pkg::rd_tag_t             tag_s2;
	logic [bsnc_pkg::SAD_W-1:0]    sad_s2;
	logic [bsnc_pkg::DIST_W-1:0]   acc_q;
	logic [bsnc_pkg::DIST_W-1:0]   sum;
	logic [bsnc_pkg::DIST_W-1:0]   best_dist_q;
	logic [bsnc_pkg::ENTRY_W-1:0]  best_entry_q;

	// Per-pixel SAD stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			tag_s2 <= tag_s1;
			sad_s2 <= bsnc_pkg::pixel_sad(blk_s1, cb_s1, chan_mask);
		end
	end

	// Restart the running sum on the first pixel of an entry
	assign sum = ((tag_s2.pix == '0) ? '0 : acc_q) + bsnc_pkg::DIST_W'(sad_s2);

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_q <= sum;
		end
	end

	// Keep the best entry; strict compare so the lowest index wins a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q  <= bsnc_pkg::DIST_ALL_ONES;
			best_entry_q <= '0;
		end else if (start) begin
			best_dist_q  <= bsnc_pkg::DIST_ALL_ONES;
			best_entry_q <= '0;
		end else if (vld_s2 && (tag_s2.pix == bsnc_pkg::PIX_LAST) && (sum < best_dist_q)) begin
			best_dist_q  <= sum;
			best_entry_q <= tag_s2.entry;
		end
	end

	assign busy       = vld_s1 | vld_s2;
	assign best_entry = best_entry_q;

endmodule

// ----- hw/rtl/block_sad_nearest_codeword_core.sv -----
// Nearest-codeword search for 4x4 blocks. Words with op 0 write one pixel of a
// codebook entry and words with op 1 load one pixel of the source block. The
// op 1 word for pixel 15 starts a search that reads one codebook pixel per
// cycle from the codebook memory over all entries in use, after which one
// best_index word is issued. No input word is taken during a search; a
// finished result waits in an output register while the next words are taken.
// The codebook needs no clearing after reset.
`include "assert_macros.svh"

module block_sad_nearest_codeword_core (
	input  logic                          clk,
	input  logic                          arst_n,
	bsnc_in_if.sink                       item,
	bsnc_out_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bsnc_pkg::PADDR_W-1:0]  paddr,
	input  logic [bsnc_pkg::DATA_W-1:0]   pwdata,
	output logic [bsnc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	bsnc_pkg::cfg_t                cfg;
	bsnc_pkg::state_t              state_q;
	bsnc_pkg::state_t              state_nxt;
	logic [bsnc_pkg::ENTRY_W-1:0]  entry_q;
	logic [bsnc_pkg::PIX_W-1:0]    pix_q;
	logic                          item_acc;
	logic                          cb_we;
	logic                          blk_we;
	logic                          start;
	logic                          rd_en;
	logic                          load_res;
	logic                          vld_s1;
	bsnc_pkg::rd_tag_t             tag_s1;
	bsnc_pkg::rd_tag_t             rd_tag;
	logic [bsnc_pkg::DATA_W-1:0]   cb_s1;
	logic [bsnc_pkg::DATA_W-1:0]   blk_s1;
	logic                          busy;
	logic [bsnc_pkg::ENTRY_W-1:0]  best_entry;
	logic                          res_vld_q;
	logic [bsnc_pkg::ENTRY_IDX_W-1:0] res_idx_q;
	logic                          last_read;

	bsnc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Decode accepted words
	assign item_acc = item.valid & item.ready;
	assign cb_we    = item_acc && (item.op == bsnc_pkg::OP_CB_WRITE) &&
		(32'(item.entry_index) < 32'(bsnc_pkg::CODEBOOK_DEPTH));
	assign blk_we   = item_acc && (item.op == bsnc_pkg::OP_BLOCK_PIXEL);
	assign start    = blk_we && (item.pixel_index == bsnc_pkg::PIX_LAST);

	assign rd_tag.entry = entry_q;
	assign rd_tag.pix   = pix_q;
	assign last_read    = (entry_q == cfg.last_entry) && (pix_q == bsnc_pkg::PIX_LAST);

	bsnc_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cb_we     (cb_we),
		.cb_waddr  ({bsnc_pkg::ENTRY_W'(item.entry_index), item.pixel_index}),
		.blk_we    (blk_we),
		.blk_waddr (item.pixel_index),
		.wdata     (item.pixel_data),
		.rd_en     (rd_en),
		.rd_tag    (rd_tag),
		.vld_s1    (vld_s1),
		.tag_s1    (tag_s1),
		.cb_s1     (cb_s1),
		.blk_s1    (blk_s1)
	);

	bsnc_sad_acc u_sad (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.chan_mask  (cfg.chan_mask),
		.vld_s1     (vld_s1),
		.tag_s1     (tag_s1),
		.cb_s1      (cb_s1),
		.blk_s1     (blk_s1),
		.busy       (busy),
		.best_entry (best_entry)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bsnc_pkg::ST_IDLE:   if (start) state_nxt = bsnc_pkg::ST_SEARCH;
			bsnc_pkg::ST_SEARCH: if (last_read) state_nxt = bsnc_pkg::ST_DRAIN;
			bsnc_pkg::ST_DRAIN:  if (!busy) state_nxt = bsnc_pkg::ST_FINISH;
			bsnc_pkg::ST_FINISH: if (!res_vld_q || result.ready) state_nxt = bsnc_pkg::ST_IDLE;
			default:             state_nxt = bsnc_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		item.ready = 1'b0;
		rd_en      = 1'b0;
		load_res   = 1'b0;
		case (state_q)
			bsnc_pkg::ST_IDLE:   item.ready = 1'b1;
			bsnc_pkg::ST_SEARCH: rd_en = 1'b1;
			bsnc_pkg::ST_DRAIN:  ;
			bsnc_pkg::ST_FINISH: load_res = !res_vld_q || result.ready;
			default:             ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsnc_pkg::ST_IDLE;
			entry_q <= '0;
			pix_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (start) begin
				entry_q <= '0;
				pix_q   <= '0;
			end else if (rd_en) begin
				// Advance pixel, then entry
				pix_q <= pix_q + 1'b1;
				if (pix_q == bsnc_pkg::PIX_LAST) begin
					entry_q <= entry_q + 1'b1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (load_res) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_idx_q <= bsnc_pkg::ENTRY_IDX_W'(best_entry);
		end
	end

	assign result.valid      = res_vld_q;
	assign result.best_index = res_idx_q;

	`BSNC_ASSERT(a_result_from_finish, clk, arst_n, $rose(res_vld_q) |-> $past(state_q == bsnc_pkg::ST_FINISH), "result raised outside finish")
	`BSNC_ASSERT(a_finish_drained, clk, arst_n, (state_q == bsnc_pkg::ST_FINISH) |-> !busy, "result taken before the pipeline drained")
	`BSNC_ASSERT_NEVER(a_no_write_in_search, clk, arst_n, (cb_we || blk_we) && (state_q != bsnc_pkg::ST_IDLE), "store written during a search")

endmodule
